// ===== hdl/p2p_stream_receiver_unit_defines.svh =====
// Assertion macros used by the stream receiver unit.
`ifndef P2P_STREAM_RECEIVER_UNIT_DEFINES_SVH
`define P2P_STREAM_RECEIVER_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define P2PSR_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define P2PSR_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// ===== hdl/p2psr_pkg.sv =====
// Package with types, codes and constants of the stream receiver.
`default_nettype none
package p2psr_pkg;
	localparam int NUM_STREAMS_DEF = 8;
	localparam int MAX_WINDOW_DEF = 16;
	localparam int BUF_BYTES_DEF = 512;

	localparam logic [1:0] OP_OPEN = 2'd0;
	localparam logic [1:0] OP_DATA = 2'd1;
	localparam logic [1:0] OP_CLACK = 2'd2;
	localparam logic [1:0] OP_TMO = 2'd3;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_OPEN = 2'd1;
	localparam logic [1:0] MODE_CLOSING = 2'd2;

	localparam logic [1:0] KIND_OPEN_ACK = 2'd0;
	localparam logic [1:0] KIND_DATA_ACK = 2'd1;
	localparam logic [1:0] KIND_CLOSE_REQ = 2'd2;

	localparam logic [1:0] TMR_NONE = 2'd0;
	localparam logic [1:0] TMR_DATA = 2'd1;
	localparam logic [1:0] TMR_CLOSE = 2'd2;
	localparam logic [1:0] TMR_CANCEL = 2'd3;

	localparam logic [1:0] MSG_NONE = 2'd0;
	localparam logic [1:0] MSG_TAKEN = 2'd1;
	localparam logic [1:0] MSG_DELIVERED = 2'd2;
	localparam logic [1:0] MSG_FREED = 2'd3;

	localparam logic [7:0] CODE_OK = 8'h80;
	localparam logic [7:0] CODE_REJECT = 8'h8c;
	localparam logic [7:0] CODE_BUSY = 8'h8d;

	localparam logic [1:0] REG_MAX_LENGTH = 2'd0;
	localparam logic [1:0] REG_OPEN_RETRIES = 2'd1;
	localparam logic [1:0] REG_DATA_RETRIES = 2'd2;
	localparam logic [1:0] REG_CLOSE_RETRIES = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [31:0] packet_word;
		logic [15:0] source_addr;
		logic [2:0] stream_id;
		logic buffer_free;
	} in_item_t;

	typedef struct packed {
		logic send_valid;
		logic [1:0] send_kind;
		logic [15:0] send_dest;
		logic [23:0] send_payload;
		logic write_valid;
		logic [2:0] write_stream;
		logic [8:0] write_offset;
		logic [23:0] write_data;
		logic [1:0] timer_action;
		logic [2:0] event_stream;
		logic [1:0] msg_event;
	} out_item_t;

	// Result of the descriptor scan, handed from the scanner to the sequencer.
	typedef struct packed {
		logic match;
		logic [2:0] match_idx;
		logic free;
		logic [2:0] free_idx;
	} scan_res_t;
endpackage
`default_nettype wire

// ===== hdl/p2psr_scan.sv =====
// Descriptor scanner: one shared compare unit checks one stream a cycle.
`default_nettype none
module p2psr_scan import p2psr_pkg::*; #(
	parameter int NUM_STREAMS = NUM_STREAMS_DEF,
	localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [1:0] mode,
	input wire logic [15:0] peer,
	input wire logic [4:0] tag,
	input wire logic [15:0] src,
	input wire logic [4:0] tid,
	output logic [SW-1:0] idx,
	output logic done,
	output scan_res_t res
);
	logic busy_q;
	logic hit;

	// One stream comparison per cycle on the selected descriptor.
	assign hit = (mode == MODE_OPEN) && (peer == src) && (tag == tid);
	assign done = busy_q && (hit || idx == SW'(NUM_STREAMS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx <= '0;
			res <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx <= '0;
			res <= '0;
		end else if (busy_q) begin
			if (hit) begin
				res.match <= 1'b1;
				res.match_idx <= 3'(idx);
			end
			if (mode == MODE_IDLE) begin
				res.free <= 1'b1;
				res.free_idx <= 3'(idx);
			end
			if (done) busy_q <= 1'b0;
			else idx <= idx + SW'(1);
		end
	end
endmodule
`default_nettype wire

// ===== hdl/p2p_stream_receiver_unit.sv =====
// An accepted open request passes through ST_SCAN, ST_EXEC and ST_OUT before its result
// is presented; any other request passes through ST_EXEC and ST_OUT.
// A new request is taken only in ST_IDLE, so each request is finished before the next;
// an open request also waits on the descriptor scan (one stream per cycle through a shared compare).
// The result sits in an output register; the next request waits until it is being taken.
// Reset (arst_n low) idles all streams, clears state and loads register defaults.
`default_nettype none
`include "p2p_stream_receiver_unit_defines.svh"
module p2p_stream_receiver_unit import p2psr_pkg::*; #(
	parameter int NUM_STREAMS = NUM_STREAMS_DEF,
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	parameter int BUF_BYTES = BUF_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
	localparam int OW = $clog2(BUF_BYTES);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_EXEC = 4'b0100,
		ST_OUT = 4'b1000
	} state_t;

	state_t state_q;
	in_item_t req_q;
	out_item_t res_q;
	logic [15:0] max_len_q;
	logic [3:0] oret_q, dret_q, cret_q;

	logic [1:0] mode_q [NUM_STREAMS];
	logic [15:0] peer_q [NUM_STREAMS];
	logic [4:0] tag_q [NUM_STREAMS];
	logic [2:0] wlog_q [NUM_STREAMS];
	logic [15:0] mask_q [NUM_STREAMS];
	logic phase_q [NUM_STREAMS];
	logic last_q [NUM_STREAMS];
	logic [16:0] woff_q [NUM_STREAMS];
	logic [15:0] mlen_q [NUM_STREAMS];
	logic [3:0] ret_q [NUM_STREAMS];

	logic [SW-1:0] scan_idx;
	logic scan_done;
	scan_res_t scan_res;
	logic scan_start;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE) && (!out_valid || out_ready);
	assign out_data = res_q;
	assign scan_start = in_valid && in_ready && in_data.opcode == OP_OPEN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 16'd280;
			oret_q <= 4'd4;
			dret_q <= 4'd4;
			cret_q <= 4'd4;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_LENGTH: max_len_q <= cfg_data;
				REG_OPEN_RETRIES: oret_q <= cfg_data[3:0];
				REG_DATA_RETRIES: dret_q <= cfg_data[3:0];
				REG_CLOSE_RETRIES: cret_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	p2psr_scan #(.NUM_STREAMS(NUM_STREAMS)) u_scan (
		.clk(clk), .arst_n(arst_n), .start(scan_start),
		.mode(mode_q[scan_idx]), .peer(peer_q[scan_idx]), .tag(tag_q[scan_idx]),
		.src(req_q.source_addr), .tid(req_q.packet_word[4:0]),
		.idx(scan_idx), .done(scan_done), .res(scan_res)
	);

	// Decoded request fields.
	logic [2:0] d_s, c_s, s;
	logic [SW-1:0] si;
	logic s_ok;
	logic [4:0] o_tid, c_tid;
	logic [2:0] o_wl;
	logic [15:0] o_len;
	logic [4:0] o_win;
	logic [3:0] seq;
	logic [16:0] pos;
	logic [15:0] bit1, m, newmask;
	logic [16:0] wadd;
	logic [15:0] mk;
	logic o_bad, d_hit, d_end, d_close, c_hit, t_hit;
	out_item_t res_n;

	always_comb begin
		o_tid = req_q.packet_word[4:0];
		o_wl = req_q.packet_word[7:5];
		o_len = req_q.packet_word[23:8];
		o_win = (o_wl > 3'd4) ? 5'd31 : 5'(5'd1 << o_wl);
		d_s = req_q.packet_word[31:29];
		c_s = req_q.packet_word[23:21];
		c_tid = req_q.packet_word[20:16];
		case (req_q.opcode)
			OP_DATA: s = d_s;
			OP_CLACK: s = c_s;
			default: s = req_q.stream_id;
		endcase
		s_ok = 32'(s) < NUM_STREAMS;
		si = SW'(s);
		mk = 16'((17'd1 << wlog_q[si]) - 17'd1);
		seq = req_q.packet_word[27:24] & 4'(mk);
		pos = woff_q[si] + 17'(seq) * 17'd3;
		d_end = pos + 17'd1 >= {1'b0, mlen_q[si]};
		bit1 = 16'd1 << seq;
		m = mask_q[si] & ~bit1;
		if (d_end) m = m & (bit1 - 16'd1);
		newmask = m;
		wadd = 17'((18'd1 << wlog_q[si]) * 18'd3);

		// Which case of each request applies.
		o_bad = o_len > max_len_q || 32'(o_win) > MAX_WINDOW;
		d_hit = s_ok && mode_q[si] == MODE_OPEN && peer_q[si] == req_q.source_addr &&
			phase_q[si] == req_q.packet_word[28];
		d_close = last_q[si] || d_end;
		c_hit = s_ok && mode_q[si] == MODE_CLOSING && tag_q[si] == c_tid &&
			peer_q[si] == req_q.source_addr;
		t_hit = s_ok && (mode_q[si] == MODE_OPEN || mode_q[si] == MODE_CLOSING);

		// Result of the request; unused fields stay zero.
		res_n = '0;
		case (req_q.opcode)
			OP_OPEN: begin
				res_n.send_valid = 1'b1;
				res_n.send_kind = KIND_OPEN_ACK;
				res_n.send_dest = req_q.source_addr;
				if (o_bad)
					res_n.send_payload = {3'd0, o_tid, 8'd0, CODE_REJECT};
				else if (scan_res.match) begin
					res_n.send_payload = {scan_res.match_idx, o_tid, 8'd0, CODE_OK};
					res_n.timer_action = TMR_DATA;
					res_n.event_stream = scan_res.match_idx;
				end else if (!scan_res.free || !req_q.buffer_free)
					res_n.send_payload = {3'd0, o_tid, 8'd0, CODE_BUSY};
				else begin
					res_n.write_valid = 1'b1;
					res_n.write_stream = scan_res.free_idx;
					res_n.write_data = {8'd0, o_len};
					res_n.send_payload = {scan_res.free_idx, o_tid, 8'd0, CODE_OK};
					res_n.timer_action = TMR_DATA;
					res_n.event_stream = scan_res.free_idx;
					res_n.msg_event = MSG_TAKEN;
				end
			end
			OP_DATA: if (d_hit) begin
				res_n.write_valid = 1'b1;
				res_n.write_stream = s;
				res_n.write_offset = 9'(OW'(pos + 17'd2));
				res_n.write_data = req_q.packet_word[23:0];
				if (newmask == 16'd0) begin
					res_n.send_valid = 1'b1;
					res_n.send_dest = peer_q[si];
					res_n.event_stream = s;
					if (d_close) begin
						res_n.send_kind = KIND_CLOSE_REQ;
						res_n.send_payload = {s, tag_q[si], 16'd0};
						res_n.timer_action = TMR_CLOSE;
					end else begin
						res_n.send_kind = KIND_DATA_ACK;
						res_n.send_payload = {2'd0, ~phase_q[si], tag_q[si], mk};
						res_n.timer_action = TMR_DATA;
					end
				end
			end
			OP_CLACK: if (c_hit) begin
				res_n.timer_action = TMR_CANCEL;
				res_n.event_stream = s;
				res_n.msg_event = MSG_DELIVERED;
			end
			default: if (t_hit) begin
				res_n.event_stream = s;
				if (ret_q[si] == 4'd0)
					res_n.msg_event = MSG_FREED;
				else begin
					res_n.send_valid = 1'b1;
					res_n.send_dest = peer_q[si];
					if (mode_q[si] == MODE_OPEN) begin
						res_n.send_kind = KIND_DATA_ACK;
						res_n.send_payload = {2'd0, phase_q[si], tag_q[si], mask_q[si]};
						res_n.timer_action = TMR_DATA;
					end else begin
						res_n.send_kind = KIND_CLOSE_REQ;
						res_n.send_payload = {s, tag_q[si], 16'd0};
						res_n.timer_action = TMR_CLOSE;
					end
				end
			end
		endcase
	end

	// Sequencer: capture, optional scan, execute, present result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			for (int i = 0; i < NUM_STREAMS; i++) begin
				mode_q[i] <= MODE_IDLE; peer_q[i] <= '0; tag_q[i] <= '0;
				wlog_q[i] <= '0; mask_q[i] <= '0; phase_q[i] <= 1'b0;
				last_q[i] <= 1'b0; woff_q[i] <= '0; mlen_q[i] <= '0;
				ret_q[i] <= '0;
			end
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid && in_ready) begin
					req_q <= in_data;
					state_q <= (in_data.opcode == OP_OPEN) ? ST_SCAN : ST_EXEC;
				end
				ST_SCAN: if (scan_done || o_bad)
					state_q <= ST_EXEC;
				ST_EXEC: begin
					res_q <= res_n;
					state_q <= ST_OUT;
					case (req_q.opcode)
						OP_OPEN: if (!o_bad) begin
							if (scan_res.match)
								ret_q[SW'(scan_res.match_idx)] <= oret_q;
							else if (scan_res.free && req_q.buffer_free) begin
								mode_q[SW'(scan_res.free_idx)] <= MODE_OPEN;
								peer_q[SW'(scan_res.free_idx)] <= req_q.source_addr;
								tag_q[SW'(scan_res.free_idx)] <= o_tid;
								wlog_q[SW'(scan_res.free_idx)] <= o_wl;
								mask_q[SW'(scan_res.free_idx)] <= 16'((17'd1 << o_wl) - 17'd1);
								phase_q[SW'(scan_res.free_idx)] <= 1'b0;
								last_q[SW'(scan_res.free_idx)] <= 1'b0;
								woff_q[SW'(scan_res.free_idx)] <= '0;
								mlen_q[SW'(scan_res.free_idx)] <= o_len;
								ret_q[SW'(scan_res.free_idx)] <= oret_q;
							end
						end
						OP_DATA: if (d_hit) begin
							if (d_end) last_q[si] <= 1'b1;
							if (newmask != 16'd0)
								mask_q[si] <= newmask;
							else if (d_close) begin
								mask_q[si] <= 16'd0;
								mode_q[si] <= MODE_CLOSING;
								ret_q[si] <= cret_q;
							end else begin
								phase_q[si] <= ~phase_q[si];
								woff_q[si] <= woff_q[si] + wadd;
								mask_q[si] <= mk;
								ret_q[si] <= dret_q;
							end
						end
						OP_CLACK: if (c_hit)
							mode_q[si] <= MODE_IDLE;
						default: if (t_hit) begin
							if (ret_q[si] == 4'd0)
								mode_q[si] <= MODE_IDLE;
							else
								ret_q[si] <= ret_q[si] - 4'd1;
						end
					endcase
				end
				ST_OUT: begin
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A result is never overwritten while waiting, requests wait for idle, and results without a send keep send_kind zero.
	`P2PSR_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE)
	`P2PSR_ASSERT_NXT(a_out_after, clk, arst_n, state_q == ST_OUT, out_valid)
	`P2PSR_ASSERT_IMP(a_send_kind, clk, arst_n, out_valid && !out_data.send_valid,
		out_data.send_kind == KIND_OPEN_ACK)
endmodule
`default_nettype wire
